FILE: rtl/triangle_mesh_volume_area_assert.svh
// ----------------------------------------------------------------------------
// triangle mesh volume and area assertion macros
// concurrent checks that vanish when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_MESH_VOLUME_AREA_ASSERT_SVH
`define TRIANGLE_MESH_VOLUME_AREA_ASSERT_SVH

`ifndef SYNTHESIS

// condition holds at every edge out of reset
`define TMVA_CHECK(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("tmva check failed");

// antecedent implies consequent in the same cycle
`define TMVA_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tmva implication failed");

// antecedent implies consequent in the next cycle
`define TMVA_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tmva next-cycle check failed");

`else

`define TMVA_CHECK(label, clk, rst, cond)
`define TMVA_IMPLY(label, clk, rst, ante, cons)
`define TMVA_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/tmva_pkg.sv
// ----------------------------------------------------------------------------
// tmva_pkg
// beat types and fixed constants of the mesh volume and area block
// ----------------------------------------------------------------------------
package tmva_pkg;

  localparam int FIELD_W = 16;
  localparam int ACC_W   = 64;
  localparam int OUT_W   = 63;

  localparam logic [OUT_W-1:0] ACC_MAX = '1;

  typedef struct packed {
    logic signed [FIELD_W-1:0] ax;
    logic signed [FIELD_W-1:0] ay;
    logic signed [FIELD_W-1:0] az;
    logic signed [FIELD_W-1:0] bx;
    logic signed [FIELD_W-1:0] by_coord;
    logic signed [FIELD_W-1:0] bz;
    logic signed [FIELD_W-1:0] cx;
    logic signed [FIELD_W-1:0] cy;
    logic signed [FIELD_W-1:0] cz;
    logic                      last_tri;
  } tmva_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] volume_six;
    logic [OUT_W-1:0] area_two;
    logic             overflow;
  } tmva_out_t;

endpackage

FILE: rtl/tmva_front.sv
// ----------------------------------------------------------------------------
// tmva_front
// four-stage pipeline: edges, partial products, cross product, squares
// ----------------------------------------------------------------------------
module tmva_front import tmva_pkg::*; #(
  parameter int CB = 16,
  parameter int DW = 17,
  parameter int PW = 35,
  parameter int VW = 53,
  parameter int NW = 72
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   tri_valid,
  output logic                   tri_stall,
  input  tmva_in_t               tri_data,
  output logic                   push,
  output logic [NW+VW:0]         push_data,
  input  logic                   full
);

  localparam int ZW = CB + 2;

  function automatic logic signed [CB-1:0] coord(input logic [FIELD_W-1:0] f);
    logic [CB-1:0] w;
    w = '0;
    for (int i = 0; i < CB && i < FIELD_W; i++) w[i] = f[i];
    return signed'(w);
  endfunction

  logic adv;

  logic                 a_valid, b_valid, c_valid, d_valid;
  logic                 a_last, b_last, c_last, d_last;
  logic signed [DW-1:0] ux, uy, uz, vx, vy, vz;
  logic signed [ZW-1:0] a_zs, b_zs, c_zs;
  logic signed [2*DW-1:0] m1, m2, m3, m4, m5, m6;
  logic signed [PW-1:0] px, py, pz;
  logic [2*PW-1:0]      sqx, sqy, sqz;
  logic signed [VW-1:0] vol;
  logic [NW-1:0]        nsum;

  assign adv       = !d_valid || !full;
  assign tri_stall = !adv;
  assign push      = d_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= tri_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      // edges a-c and a-b, z corner sum
      ux   <= DW'(coord(tri_data.ax)) - DW'(coord(tri_data.cx));
      uy   <= DW'(coord(tri_data.ay)) - DW'(coord(tri_data.cy));
      uz   <= DW'(coord(tri_data.az)) - DW'(coord(tri_data.cz));
      vx   <= DW'(coord(tri_data.ax)) - DW'(coord(tri_data.bx));
      vy   <= DW'(coord(tri_data.ay)) - DW'(coord(tri_data.by_coord));
      vz   <= DW'(coord(tri_data.az)) - DW'(coord(tri_data.bz));
      a_zs <= ZW'(coord(tri_data.az)) + ZW'(coord(tri_data.bz))
            + ZW'(coord(tri_data.cz));
      a_last <= tri_data.last_tri;
      // partial products
      m1 <= uy * vz;
      m2 <= uz * vy;
      m3 <= uz * vx;
      m4 <= ux * vz;
      m5 <= ux * vy;
      m6 <= uy * vx;
      b_zs   <= a_zs;
      b_last <= a_last;
      // cross product
      px <= PW'(m1) - PW'(m2);
      py <= PW'(m3) - PW'(m4);
      pz <= PW'(m5) - PW'(m6);
      c_zs   <= b_zs;
      c_last <= b_last;
      // squares and signed volume term
      sqx <= px * px;
      sqy <= py * py;
      sqz <= pz * pz;
      vol <= pz * c_zs;
      d_last <= c_last;
    end
  end

  assign nsum      = NW'(sqx) + NW'(sqy) + NW'(sqz);
  assign push_data = {nsum, vol, d_last};

endmodule

FILE: rtl/tmva_queue.sv
// ----------------------------------------------------------------------------
// tmva_queue
// small fifo between the front pipeline and the root/accumulate unit
// ----------------------------------------------------------------------------
`include "triangle_mesh_volume_area_assert.svh"

module tmva_queue import tmva_pkg::*; #(
  parameter int QW    = 108,
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [QW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output logic [QW-1:0] rd_data
);

  localparam int PTR = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT = $clog2(DEPTH + 1);

  logic [QW-1:0]  mem [DEPTH];
  logic [PTR-1:0] wr_ptr, rd_ptr;
  logic [CNT-1:0] count;

  assign full  = (count == CNT'(DEPTH));
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
    if (pop)  rd_data     <= mem[rd_ptr];
  end

  `TMVA_IMPLY(a_no_overrun, clk, rst, push, !full)
  `TMVA_IMPLY(a_no_underrun, clk, rst, pop, !empty)

endmodule

FILE: rtl/tmva_back.sv
// ----------------------------------------------------------------------------
// tmva_back
// bit-pair square root, saturating accumulators and result register
// ----------------------------------------------------------------------------
`include "triangle_mesh_volume_area_assert.svh"

module tmva_back import tmva_pkg::*; #(
  parameter int VW = 53,
  parameter int NW = 72
) (
  input  logic            clk,
  input  logic            rst,
  output logic            pop,
  input  logic            empty,
  input  logic [NW+VW:0]  rd_data,
  output logic            sum_valid,
  input  logic            sum_stall,
  output tmva_out_t       sum_data
);

  localparam int RB = NW / 2;
  localparam int CW = $clog2(RB);
  localparam int AW = ((VW > ACC_W) ? VW : ACC_W) + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_ROOT = 2'd2;
  localparam logic [1:0] S_ACC  = 2'd3;

  logic [1:0]              state;
  logic [CW-1:0]           cnt;
  logic [NW-1:0]           rad;
  logic [RB:0]             rem;
  logic [RB-1:0]           root;
  logic signed [VW-1:0]    vol_q;
  logic                    last_q;

  logic signed [ACC_W-1:0] vol_acc, vol_next;
  logic [OUT_W-1:0]        area_acc, area_next;
  logic                    sat, sat_next;

  logic [RB+2:0]           rem_sh, trial;
  logic                    ge;
  logic [RB:0]             len;
  logic signed [AW-1:0]    vsum, vmax;
  logic [ACC_W-1:0]        asum;
  logic [ACC_W-1:0]        vmag;
  logic                    can_out, finish;

  assign pop = (state == S_IDLE) && !empty;

  // one root bit per step
  assign rem_sh = {rem, rad[NW-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign ge     = rem_sh >= trial;

  // round to nearest: remainder above root means n > r*r + r
  assign len = {1'b0, root} + ((rem > {1'b0, root}) ? 1'b1 : 1'b0);

  assign vmax = AW'(signed'({1'b0, ACC_MAX}));
  assign vsum = AW'(vol_acc) + AW'(vol_q);
  assign asum = ACC_W'(area_acc) + ACC_W'(len);

  always_comb begin
    vol_next = ACC_W'(vsum);
    sat_next = sat;
    if (vsum > vmax) begin
      vol_next = ACC_W'(vmax);
      sat_next = 1'b1;
    end else if (vsum < -vmax) begin
      vol_next = ACC_W'(-vmax);
      sat_next = 1'b1;
    end
    area_next = OUT_W'(asum);
    if (asum > ACC_W'(ACC_MAX)) begin
      area_next = ACC_MAX;
      sat_next  = 1'b1;
    end
  end

  assign vmag    = vol_next[ACC_W-1] ? ACC_W'(-vol_next) : ACC_W'(vol_next);
  assign can_out = !sum_valid || !sum_stall;
  assign finish  = (state == S_ACC) && (!last_q || can_out);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      vol_acc  <= '0;
      area_acc <= '0;
      sat      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (pop) state <= S_LOAD;
        end
        S_LOAD: begin
          cnt   <= CW'(RB - 1);
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (cnt == '0) state <= S_ACC;
          else cnt <= cnt - 1'b1;
        end
        S_ACC: begin
          if (finish) begin
            state <= S_IDLE;
            if (last_q) begin
              vol_acc  <= '0;
              area_acc <= '0;
              sat      <= 1'b0;
            end else begin
              vol_acc  <= vol_next;
              area_acc <= area_next;
              sat      <= sat_next;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_LOAD: begin
        rad    <= rd_data[NW+VW:VW+1];
        vol_q  <= signed'(rd_data[VW:1]);
        last_q <= rd_data[0];
        rem    <= '0;
        root   <= '0;
      end
      S_ROOT: begin
        rad  <= {rad[NW-3:0], 2'b00};
        rem  <= ge ? (RB+1)'(rem_sh - trial) : (RB+1)'(rem_sh);
        root <= {root[RB-2:0], ge};
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (finish && last_q) begin
      sum_valid <= 1'b1;
    end else if (!sum_stall) begin
      sum_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish && last_q) begin
      sum_data.volume_six <= vmag[OUT_W-1:0];
      sum_data.area_two   <= area_next;
      sum_data.overflow   <= sat_next;
    end
  end

  `TMVA_NEXT(a_clear_after_last, clk, rst, finish && last_q,
    vol_acc == '0 && area_acc == '0 && !sat)
  `TMVA_CHECK(a_vol_clamped, clk, rst, vol_acc != {1'b1, {(ACC_W-1){1'b0}}})

endmodule

FILE: rtl/triangle_mesh_volume_area.sv
// ----------------------------------------------------------------------------
// triangle_mesh_volume_area
// closed-mesh volume and surface area accumulator
// ----------------------------------------------------------------------------
// Each tri beat carries one triangle of a closed mesh; on the beat marked
// last_tri one sum beat follows with six times the enclosed volume (absolute),
// twice the surface area and a saturation flag, and the sums restart at zero.
// Dividing by six and two and unit conversion stay in software. A four-stage
// front pipeline forms the edges, the cross product and its squares; a queue
// of QUEUE_DEPTH entries feeds the back unit, which takes an integer square
// root one bit per cycle and works on one triangle at a time; that root
// loop sets the sustained rate, and the front keeps taking triangles until
// the queue fills. A degenerate triangle adds zero. Coordinates use the low
// COORD_BITS bits of each field, sign-extended.
// ----------------------------------------------------------------------------
module triangle_mesh_volume_area import tmva_pkg::*; #(
  parameter int COORD_BITS  = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      tri_valid,
  output logic      tri_stall,
  input  tmva_in_t  tri_data,
  output logic      sum_valid,
  input  logic      sum_stall,
  output tmva_out_t sum_data
);

  // edge, cross-product, volume-term, radicand and queue widths
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW + 1;
  localparam int VW = PW + COORD_BITS + 2;
  localparam int NW = 2 * PW + 2;
  localparam int QW = NW + VW + 1;

  logic          push, full, pop, empty;
  logic [QW-1:0] push_data, rd_data;

  tmva_front #(
    .CB (COORD_BITS),
    .DW (DW),
    .PW (PW),
    .VW (VW),
    .NW (NW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .tri_valid (tri_valid),
    .tri_stall (tri_stall),
    .tri_data  (tri_data),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  // decouples the pipelined front from the iterative back
  tmva_queue #(
    .QW    (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .rd_data   (rd_data)
  );

  tmva_back #(
    .VW (VW),
    .NW (NW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop       (pop),
    .empty     (empty),
    .rd_data   (rd_data),
    .sum_valid (sum_valid),
    .sum_stall (sum_stall),
    .sum_data  (sum_data)
  );

endmodule
